// File: sv/gls_pkg.sv
// ----------------------------------------------------------------------------
// gls_pkg
// Shared types and codes for the grid line-of-sight walk unit.
// ----------------------------------------------------------------------------
package gls_pkg;

    // Command codes carried in the command field of an input word.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_WALK  = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_MAP_WIDTH  = 1'b0;
    localparam logic CFG_MAP_HEIGHT = 1'b1;

    // Reset value of both map bound registers.
    localparam logic [6:0] MAP_BOUND_RESET = 7'd64;

    typedef struct packed {
        logic              command;
        logic [5:0]        cell_x;
        logic [5:0]        cell_y;
        logic              cell_wall;
        logic signed [7:0] origin_x;
        logic signed [7:0] origin_y;
        logic signed [7:0] goal_x;
        logic signed [7:0] goal_y;
    } t_in_word;

    typedef struct packed {
        logic signed [7:0] stop_x;
        logic signed [7:0] stop_y;
        logic              reached_goal;
    } t_out_word;

    // One step of the walk: the next cell and whether it lies on the map.
    typedef struct packed {
        logic signed [7:0] x;
        logic signed [7:0] y;
        logic              in_bounds;
    } t_step;

endpackage

// File: sv/gls_ram.sv
// ----------------------------------------------------------------------------
// gls_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module gls_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: sv/gls_step.sv
// ----------------------------------------------------------------------------
// gls_step
// One step of the walk: picks the axis, moves one cell toward the goal and
// checks the new cell against the map bounds.
// ----------------------------------------------------------------------------
module gls_step (
    input  logic signed [7:0] i_px,
    input  logic signed [7:0] i_py,
    input  logic signed [7:0] i_gx,
    input  logic signed [7:0] i_gy,
    input  logic [7:0]        i_lim_x,
    input  logic [7:0]        i_lim_y,
    output gls_pkg::t_step    o_step
);
    import gls_pkg::*;

    logic signed [8:0] dx;
    logic signed [8:0] dy;
    logic [8:0]        adx;
    logic [8:0]        ady;
    logic              move_x;
    logic signed [7:0] inc_x;
    logic signed [7:0] inc_y;
    logic signed [7:0] nx;
    logic signed [7:0] ny;

    always_comb begin
        dx     = {i_gx[7], i_gx} - {i_px[7], i_px};
        dy     = {i_gy[7], i_gy} - {i_py[7], i_py};
        adx    = dx[8] ? 9'(-dx) : 9'(dx);
        ady    = dy[8] ? 9'(-dy) : 9'(dy);
        move_x = adx > ady;
        inc_x  = dx[8] ? 8'sh FF : 8'sh01;
        // y is only stepped with a zero y distance at the goal, where no step is taken.
        inc_y  = dy[8] ? 8'sh FF : ((dy == 9'sd0) ? 8'sh00 : 8'sh01);
        nx     = move_x ? 8'(i_px + inc_x) : i_px;
        ny     = move_x ? i_py : 8'(i_py + inc_y);

        o_step.x         = nx;
        o_step.y         = ny;
        o_step.in_bounds = !nx[7] && !ny[7]
                           && ({1'b0, nx[6:0]} < i_lim_x)
                           && ({1'b0, ny[6:0]} < i_lim_y);
    end

endmodule

// File: sv/grid_line_of_sight_walk_unit.sv
// ----------------------------------------------------------------------------
// grid_line_of_sight_walk_unit
// Wall map of a square grid with a cell-by-cell line-of-sight walk.
// ----------------------------------------------------------------------------
// The wall map is held one row per memory word in a MAP_SIDE x MAP_SIDE bit
// RAM. After reset the unit runs a clearing pass, one row per cycle, during
// which no input word is taken; configuration writes are taken at any time.
// A write word has its row read when it is taken, then written back with the
// one bit changed in the write state. A write outside the stored grid is
// dropped without touching the RAM. In a walk, each cycle checks the cell read
// in the previous cycle and issues the read for the next one, so the RAM read
// port sets the pace at one cell per cycle. Every checked cell except a final
// blocking one lies on the map and the walk never turns back, so at most
// 2*MAP_SIDE cells are checked. A walk whose origin is its goal issues no read
// and goes straight to the done state. The unit works on one word at a time;
// the finished result sits in an output register, so the next input word is
// taken while the previous result still waits to be collected, but a finished
// walk waits in the done state for as long as that earlier result has not been
// collected. The origin cell itself is never checked, and a cell outside
// map_width or map_height stops the walk just as a wall does.
// ----------------------------------------------------------------------------
module grid_line_of_sight_walk_unit #(
    parameter int MAP_SIDE = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  gls_pkg::t_in_word   i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output gls_pkg::t_out_word  o_out,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_index,
    input  logic [6:0]          i_cfg_data
);
    import gls_pkg::*;

    localparam int              AW       = $clog2(MAP_SIDE);
    localparam logic [7:0]      SIDE8    = 8'(MAP_SIDE);
    localparam logic [AW-1:0]   LAST_ROW = AW'(MAP_SIDE - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRITE,
        ST_WALK,
        ST_DONE
    } t_state;

    t_state            r_state;
    logic [AW-1:0]     r_clr_row;
    logic [6:0]        r_map_width;
    logic [6:0]        r_map_height;

    // Pending cell write.
    logic [AW-1:0]     r_wr_row;
    logic [AW-1:0]     r_wr_col;
    logic              r_wr_bit;

    // Walk state: the candidate cell whose row is being read, whether it is
    // on the map, the last free cell and the goal.
    logic signed [7:0] r_cx;
    logic signed [7:0] r_cy;
    logic              r_c_in;
    logic signed [7:0] r_lx;
    logic signed [7:0] r_ly;
    logic signed [7:0] r_gx;
    logic signed [7:0] r_gy;

    t_out_word         r_res;
    t_out_word         r_out;
    logic              r_out_valid;

    logic              in_acc;
    logic              out_free;
    logic [7:0]        lim_x;
    logic [7:0]        lim_y;
    logic [7:0]        cell_x8;
    logic [7:0]        cell_y8;
    logic              wr_in_range;
    logic              walk_trivial;
    logic signed [7:0] base_x;
    logic signed [7:0] base_y;
    logic signed [7:0] goal_x;
    logic signed [7:0] goal_y;
    t_step             step;
    logic              cand_wall;
    logic              cand_blocked;
    logic              cand_goal;

    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [MAP_SIDE-1:0] rd_data;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [MAP_SIDE-1:0] wr_data;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    // Bounds above the stored grid act as the grid side.
    assign lim_x = ({1'b0, r_map_width} > SIDE8) ? SIDE8 : {1'b0, r_map_width};
    assign lim_y = ({1'b0, r_map_height} > SIDE8) ? SIDE8 : {1'b0, r_map_height};

    assign cell_x8     = {2'b00, i_in.cell_x};
    assign cell_y8     = {2'b00, i_in.cell_y};
    assign wr_in_range = (cell_x8 < SIDE8) && (cell_y8 < SIDE8);

    assign walk_trivial = (i_in.origin_x == i_in.goal_x)
                          && (i_in.origin_y == i_in.goal_y);

    // The step unit works from the origin when a walk starts and from the
    // current candidate while it runs.
    assign base_x = (r_state == ST_IDLE) ? i_in.origin_x : r_cx;
    assign base_y = (r_state == ST_IDLE) ? i_in.origin_y : r_cy;
    assign goal_x = (r_state == ST_IDLE) ? i_in.goal_x : r_gx;
    assign goal_y = (r_state == ST_IDLE) ? i_in.goal_y : r_gy;

    gls_step u_step (
        .i_px    (base_x),
        .i_py    (base_y),
        .i_gx    (goal_x),
        .i_gy    (goal_y),
        .i_lim_x (lim_x),
        .i_lim_y (lim_y),
        .o_step  (step)
    );

    // The row read last cycle belongs to the candidate; an off-map candidate
    // never issued a read and is blocked regardless of the data.
    assign cand_wall    = rd_data[r_cx[AW-1:0]];
    assign cand_blocked = !r_c_in || cand_wall;
    assign cand_goal    = (r_cx == r_gx) && (r_cy == r_gy);

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = step.y[AW-1:0];
        wr_en   = 1'b0;
        wr_addr = r_wr_row;
        wr_data = rd_data;
        wr_data[r_wr_col] = r_wr_bit;
        case (r_state)
            ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr_row;
                wr_data = '0;
            end
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_in.command == CMD_WRITE) begin
                        rd_en   = wr_in_range;
                        rd_addr = cell_y8[AW-1:0];
                    end else begin
                        rd_en = !walk_trivial && step.in_bounds;
                    end
                end
            end
            ST_WRITE: begin
                wr_en = 1'b1;
            end
            ST_WALK: begin
                rd_en = !cand_blocked && !cand_goal && step.in_bounds;
            end
            default: begin
            end
        endcase
    end

    gls_ram #(
        .WIDTH (MAP_SIDE),
        .DEPTH (MAP_SIDE)
    ) u_map_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_clr_row    <= '0;
            r_map_width  <= MAP_BOUND_RESET;
            r_map_height <= MAP_BOUND_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_MAP_WIDTH:  r_map_width  <= i_cfg_data;
                    CFG_MAP_HEIGHT: r_map_height <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            // A finished result moves into the output register as soon as the
            // previous one has gone or is leaving in this cycle.
            if ((r_state == ST_DONE) && out_free) begin
                r_out       <= r_res;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_CLEAR: begin
                    r_clr_row <= AW'(r_clr_row + 1'b1);
                    if (r_clr_row == LAST_ROW) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (in_acc) begin
                        if (i_in.command == CMD_WRITE) begin
                            r_wr_row <= cell_y8[AW-1:0];
                            r_wr_col <= cell_x8[AW-1:0];
                            r_wr_bit <= i_in.cell_wall;
                            if (wr_in_range) begin
                                r_state <= ST_WRITE;
                            end
                        end else begin
                            r_gx <= i_in.goal_x;
                            r_gy <= i_in.goal_y;
                            r_lx <= i_in.origin_x;
                            r_ly <= i_in.origin_y;
                            if (walk_trivial) begin
                                r_res.stop_x       <= i_in.goal_x;
                                r_res.stop_y       <= i_in.goal_y;
                                r_res.reached_goal <= 1'b1;
                                r_state            <= ST_DONE;
                            end else begin
                                r_cx    <= step.x;
                                r_cy    <= step.y;
                                r_c_in  <= step.in_bounds;
                                r_state <= ST_WALK;
                            end
                        end
                    end
                end
                ST_WRITE: begin
                    r_state <= ST_IDLE;
                end
                ST_WALK: begin
                    if (cand_blocked) begin
                        r_res.stop_x       <= r_lx;
                        r_res.stop_y       <= r_ly;
                        r_res.reached_goal <= 1'b0;
                        r_state            <= ST_DONE;
                    end else if (cand_goal) begin
                        r_res.stop_x       <= r_gx;
                        r_res.stop_y       <= r_gy;
                        r_res.reached_goal <= 1'b1;
                        r_state            <= ST_DONE;
                    end else begin
                        r_lx   <= r_cx;
                        r_ly   <= r_cy;
                        r_cx   <= step.x;
                        r_cy   <= step.y;
                        r_c_in <= step.in_bounds;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// File: sv/gls_checker.sv
// ----------------------------------------------------------------------------
// gls_checker
// Port-level checks for the grid line-of-sight walk unit, bound to its top.
// ----------------------------------------------------------------------------
module gls_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               o_in_ready,
    input  gls_pkg::t_in_word  i_in,
    input  logic               o_out_valid,
    input  logic               i_out_ready,
    input  gls_pkg::t_out_word o_out
);
    import gls_pkg::*;

    // Reset empties the output register.
    a_reset_empties_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result word valid straight after reset");

    // The clearing pass holds off input words in the first cycle after reset.
    a_clear_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !o_in_ready)
        else $error("input word taken during map clearing pass");

    // An accepted walk takes the unit out of the idle state, so input readiness drops.
    a_walk_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in.command == CMD_WALK) |=> !o_in_ready)
        else $error("input word taken in the cycle after a walk started");

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out)))
        else $error("result word changed or dropped while stalled");

endmodule

bind grid_line_of_sight_walk_unit gls_checker u_gls_checker (.*);

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the grid line-of-sight walk unit: map writes, walk
// queries and bound settings are driven through the valid/ready channels and
// every result word is compared with an in-bench prediction of the walk.
// ----------------------------------------------------------------------------
module testbench;
    import gls_pkg::*;

    localparam int MAP_SIDE     = 64;
    localparam int HALF_PERIOD  = 10;
    localparam int RESET_CYCLES = 12;
    localparam int IDLE_PERCENT = 24;
    // A walk checks at most twice the grid side in cells, so this covers the
    // longest one in flight many times over.
    localparam int DRAIN_CYCLES = 600;
    // Long enough for a trailing map write to finish and leave the unit idle.
    localparam int SETTLE_CYCLES = 8;
    localparam int REPORT_LIMIT = 10;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic       o_in_ready;
    t_in_word   i_in        = '0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    t_out_word  o_out;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic       i_cfg_index = CFG_MAP_WIDTH;
    logic [6:0] i_cfg_data  = '0;

    // Bench copy of the wall map and of the two bound registers.
    bit         wall_bits [MAP_SIDE * MAP_SIDE];
    logic [6:0] cols_in_use = MAP_BOUND_RESET;
    logic [6:0] rows_in_use = MAP_BOUND_RESET;

    // Stop cells predicted for walks that have been accepted, oldest first.
    t_out_word  pending_stops [$];
    int         mismatches = 0;
    // While set, neither side idles.
    bit         steady = 1'b0;

    grid_line_of_sight_walk_unit #(
        .MAP_SIDE (MAP_SIDE)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // The receiver holds ready low in about a quarter of the cycles, except
    // during a steady stretch.
    always @(negedge i_clk) begin
        i_out_ready <= steady ? 1'b1 : ($urandom_range(99) >= IDLE_PERCENT);
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic int span(input int d);
        return (d < 0) ? -d : d;
    endfunction

    function automatic int direction(input int d);
        if (d > 0)
            return 1;
        else if (d < 0)
            return -1;
        return 0;
    endfunction

    // A cell stops the walk when it lies off the map in use or holds a wall.
    // Bounds beyond the stored grid behave as the full grid.
    function automatic bit cell_blocked(input int x, input int y);
        int cols;
        int rows;
        cols = (cols_in_use > MAP_SIDE) ? MAP_SIDE : int'(cols_in_use);
        rows = (rows_in_use > MAP_SIDE) ? MAP_SIDE : int'(rows_in_use);
        if (x < 0 || y < 0 || x >= cols || y >= rows)
            return 1'b1;
        return wall_bits[y * MAP_SIDE + x];
    endfunction

    // Steps from origin to goal, along x only while the x distance left is
    // strictly larger than the y distance left. The origin itself is never
    // tested, so a walk whose origin equals its goal always arrives.
    function automatic t_out_word predict_walk(input t_in_word w);
        int        ox, oy, gx, gy;
        int        sx, sy;
        int        px, py;
        int        lx, ly;
        bit        hit;
        t_out_word stop;
        ox  = $signed(w.origin_x);
        oy  = $signed(w.origin_y);
        gx  = $signed(w.goal_x);
        gy  = $signed(w.goal_y);
        sx  = direction(gx - ox);
        sy  = direction(gy - oy);
        px  = ox;
        py  = oy;
        lx  = ox;
        ly  = oy;
        hit = 1'b0;
        while (px != gx || py != gy) begin
            if (span(gx - px) > span(gy - py))
                px += sx;
            else
                py += sy;
            if (cell_blocked(px, py)) begin
                hit = 1'b1;
                break;
            end
            lx = px;
            ly = py;
        end
        if (!hit) begin
            lx = gx;
            ly = gy;
        end
        stop.stop_x       = lx[7:0];
        stop.stop_y       = ly[7:0];
        stop.reached_goal = !hit;
        return stop;
    endfunction

    // ------------------------------------------------------------------------
    // Word builders: the fields that the command ignores carry random junk.
    // ------------------------------------------------------------------------
    function automatic t_in_word make_write(input int x, input int y, input bit wall);
        t_in_word w;
        w.command   = CMD_WRITE;
        w.cell_x    = x[5:0];
        w.cell_y    = y[5:0];
        w.cell_wall = wall;
        w.origin_x  = 8'($urandom());
        w.origin_y  = 8'($urandom());
        w.goal_x    = 8'($urandom());
        w.goal_y    = 8'($urandom());
        return w;
    endfunction

    function automatic t_in_word make_walk(input int ox, input int oy,
                                           input int gx, input int gy);
        t_in_word w;
        w.command   = CMD_WALK;
        w.cell_x    = 6'($urandom());
        w.cell_y    = 6'($urandom());
        w.cell_wall = 1'($urandom());
        w.origin_x  = ox[7:0];
        w.origin_y  = oy[7:0];
        w.goal_x    = gx[7:0];
        w.goal_y    = gy[7:0];
        return w;
    endfunction

    function automatic int rand_in(input int lo, input int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    // ------------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------------
    // Presents one input word, with random idle cycles in front of it, and
    // updates the prediction once the word has been taken. Valid is left high
    // so that back-to-back words need no drop in between.
    task automatic send_word(input t_in_word w);
        @(negedge i_clk);
        while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in       <= w;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        if (w.command == CMD_WALK)
            pending_stops.push_back(predict_walk(w));
        else
            wall_bits[int'(w.cell_y) * MAP_SIDE + int'(w.cell_x)] = w.cell_wall;
    endtask

    // Stops sending, waits for every predicted result word to be collected and
    // then lets a trailing map write finish, so that the unit is idle.
    task automatic wait_quiet();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_stops.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES)
            @(posedge i_clk);
    endtask

    task automatic write_bound(input logic index, input logic [6:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        if (index == CFG_MAP_WIDTH)
            cols_in_use = value;
        else
            rows_in_use = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // The bounds are only changed while nothing is in flight.
    task automatic set_bounds(input int cols, input int rows);
        wait_quiet();
        write_bound(CFG_MAP_WIDTH, cols[6:0]);
        write_bound(CFG_MAP_HEIGHT, rows[6:0]);
    endtask

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_stops.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result word: x=%0d y=%0d reached=%0b",
                             o_out.stop_x, o_out.stop_y, o_out.reached_goal);
            end else begin
                want = pending_stops.pop_front();
                if (o_out.stop_x !== want.stop_x || o_out.stop_y !== want.stop_y ||
                    o_out.reached_goal !== want.reached_goal) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("stop mismatch: want %0d,%0d,%0b got %0d,%0d,%0b",
                                 want.stop_x, want.stop_y, want.reached_goal,
                                 o_out.stop_x, o_out.stop_y, o_out.reached_goal);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Walks over the empty full-size map: a walk that starts on its goal, the
    // coordinate extremes, and walks that start off the map or leave it.
    task automatic test_open_walks();
        send_word(make_walk(10, 10, 10, 10));
        send_word(make_walk(-128, 127, -128, 127));
        send_word(make_walk(0, 0, 63, 63));
        send_word(make_walk(-128, -128, 127, 127));
        send_word(make_walk(127, 127, -128, -128));
        send_word(make_walk(-3, 5, 10, 5));
        send_word(make_walk(60, 60, 70, 60));
    endtask

    // Walls stop a walk just before them, a wall under the origin is not
    // looked at, and clearing a wall opens the way again.
    task automatic test_wall_stops();
        send_word(make_write(5, 0, 1'b1));
        send_word(make_walk(0, 0, 10, 0));
        send_word(make_write(20, 20, 1'b1));
        send_word(make_walk(20, 20, 25, 20));
        send_word(make_write(63, 63, 1'b1));
        send_word(make_walk(60, 63, 63, 63));
        send_word(make_write(0, 0, 1'b1));
        send_word(make_walk(3, 0, 0, 0));
        send_word(make_write(5, 0, 1'b0));
        send_word(make_walk(0, 0, 10, 0));
    endtask

    // Bounds of zero, bounds above the stored grid, and a one-cell map on
    // which a write outside the bounds is still kept for later.
    task automatic test_map_bounds();
        set_bounds(0, 0);
        send_word(make_walk(5, 5, 5, 8));
        send_word(make_walk(3, 3, 3, 3));
        set_bounds(127, 127);
        send_word(make_walk(0, 0, 63, 0));
        send_word(make_walk(0, 0, 64, 0));
        set_bounds(1, 1);
        send_word(make_write(10, 10, 1'b1));
        send_word(make_walk(0, 0, 0, 3));
        set_bounds(64, 64);
        send_word(make_walk(10, 5, 10, 15));
    endtask

    // One random phase under one bound setting. Most walks start and end on or
    // just around the map so that they travel far; the rest use any origin and
    // goal, or start on their goal. Writes mostly land on or just around the map in use.
    task automatic run_phase(input int cols, input int rows, input int words,
                             input int wall_pct, input bit calm, input bit pause_midway);
        int       hx;
        int       hy;
        int       pick;
        t_in_word w;
        set_bounds(cols, rows);
        steady = calm;
        hx = ((cols > MAP_SIDE) ? MAP_SIDE : cols) + 1;
        hy = ((rows > MAP_SIDE) ? MAP_SIDE : rows) + 1;
        for (int n = 0; n < words; n++) begin
            pick = $urandom_range(99);
            if (pick < 30)
                w = make_write(($urandom_range(3) == 0) ? rand_in(0, 63)
                                                        : rand_in(0, (hx > 63) ? 63 : hx),
                               ($urandom_range(3) == 0) ? rand_in(0, 63)
                                                        : rand_in(0, (hy > 63) ? 63 : hy),
                               $urandom_range(99) < wall_pct);
            else if (pick < 80)
                w = make_walk(rand_in(-2, hx), rand_in(-2, hy), rand_in(-2, hx),
                              rand_in(-2, hy));
            else if (pick < 88) begin
                w = make_walk($urandom(), $urandom(), 0, 0);
                w.goal_x = w.origin_x;
                w.goal_y = w.origin_y;
            end else
                w = make_walk($urandom(), $urandom(), $urandom(), $urandom());
            send_word(w);
            // Hold the sender back once until every result has been collected.
            if (pause_midway && n == words / 2)
                wait_quiet();
        end
        steady = 1'b0;
    endtask

    task automatic test_random_walks();
        run_phase(64, 64, 200, 25, 1'b0, 1'b0);
        run_phase(16, 40, 120, 35, 1'b0, 1'b0);
        run_phase(127, 127, 150, 20, 1'b1, 1'b0);
        run_phase(1, 64, 40, 30, 1'b0, 1'b0);
        run_phase(64, 1, 40, 30, 1'b0, 1'b0);
        run_phase(0, 0, 20, 30, 1'b0, 1'b0);
        run_phase(37, 9, 80, 40, 1'b0, 1'b0);
        run_phase(64, 64, 200, 10, 1'b0, 1'b1);
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (RESET_CYCLES)
            @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_open_walks();
        test_wall_stops();
        test_map_bounds();
        test_random_walks();
        wait_quiet();
        repeat (DRAIN_CYCLES)
            @(posedge i_clk);
        if (mismatches == 0 && pending_stops.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Guard against a hang anywhere in the run.
    initial begin
        #25ms;
        $display("Some tests failed");
        $finish;
    end

endmodule
